// File: design/bsc_pkg.sv
// Shared types, codes and constants of the banker's safety and request checker.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 4;

    localparam int AMT_W       = 8;
    localparam int WORK_W      = 12;
    localparam int FIELD_LANES = 4;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [WORK_W-1:0] WORK_MAX = 12'd4095;

    // command codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_AVAIL = 2'd1;
    localparam logic [1:0] OP_REQ   = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    // result status codes
    localparam logic [2:0] ST_LOADED   = 3'd0;
    localparam logic [2:0] ST_GRANTED  = 3'd1;
    localparam logic [2:0] ST_EXCEEDS  = 3'd2;
    localparam logic [2:0] ST_UNAVAIL  = 3'd3;
    localparam logic [2:0] ST_DENIED   = 3'd4;
    localparam logic [2:0] ST_SEQ      = 3'd5;
    localparam logic [2:0] ST_UNSAFE   = 3'd6;
    localparam logic [2:0] ST_INVALID  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RES  = 2'd1;

    localparam logic [4:0] ACTIVE_PROC_RST = 5'd5;
    localparam logic [2:0] ACTIVE_RES_RST  = 3'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] process;
        logic [7:0] amt_0;
        logic [7:0] amt_1;
        logic [7:0] amt_2;
        logic [7:0] amt_3;
        logic [7:0] limit_0;
        logic [7:0] limit_1;
        logic [7:0] limit_2;
        logic [7:0] limit_3;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] seq_process;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_RQ_RD,
        S_RQ_AV,
        S_SCAN_INIT,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

// File: design/bsc_row_mem.sv
// Process row memory: allocation and need rows, one row per process, registered read.
`timescale 1ns / 1ps

module bsc_row_mem #(
    parameter int DEPTH = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int LANES = bsc_pkg::MAX_RESOURCES_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     rd_en,
    input  logic [$clog2(DEPTH)-1:0]                 rd_addr,
    output logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     rd_alloc,
    output logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     rd_need,
    input  logic                                     wr_en,
    input  logic [$clog2(DEPTH)-1:0]                 wr_addr,
    input  logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     wr_alloc,
    input  logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     wr_need
);
    import bsc_pkg::*;

    logic [LANES-1:0][AMT_W-1:0] alloc_mem [DEPTH];
    logic [LANES-1:0][AMT_W-1:0] need_mem  [DEPTH];
    logic [DEPTH-1:0]            row_valid_reg;
    logic [LANES-1:0][AMT_W-1:0] alloc_q_reg;
    logic [LANES-1:0][AMT_W-1:0] need_q_reg;
    logic                        q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            alloc_mem[wr_addr] <= wr_alloc;
            need_mem[wr_addr]  <= wr_need;
        end
        if (rd_en)
        begin
            alloc_q_reg <= alloc_mem[rd_addr];
            need_q_reg  <= need_mem[rd_addr];
        end
    end

    // never-written rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            q_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_alloc = q_valid_reg ? alloc_q_reg : '0;
    assign rd_need  = q_valid_reg ? need_q_reg  : '0;

endmodule

// File: design/bsc_lane_unit.sv
// Shared lane unit: per-resource compare against a base vector and saturating add.
`timescale 1ns / 1ps

module bsc_lane_unit #(
    parameter int LANES = bsc_pkg::MAX_RESOURCES_DEF
) (
    input  logic [LANES-1:0]                         lane_act,
    input  logic [LANES-1:0][bsc_pkg::WORK_W-1:0]    base,
    input  logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     cmp,
    input  logic [LANES-1:0][bsc_pkg::AMT_W-1:0]     add,
    output logic                                     fits,
    output logic [LANES-1:0][bsc_pkg::WORK_W-1:0]    sum
);
    import bsc_pkg::*;

    logic [WORK_W:0] wide;

    always_comb
    begin
        fits = 1'b1;
        sum  = base;
        wide = '0;
        for (int r = 0; r < LANES; r++)
        begin
            if (lane_act[r])
            begin
                if (WORK_W'(cmp[r]) > base[r])
                begin
                    fits = 1'b0;
                end
                wide = {1'b0, base[r]} + (WORK_W + 1)'(add[r]);
                sum[r] = wide[WORK_W] ? WORK_MAX : wide[WORK_W-1:0];
            end
        end
    end

endmodule

// File: design/bankers_safety_and_request_check_top.sv
// Top level of the banker's safety and request checker: sequencer, tables and config.
`timescale 1ns / 1ps

// Usage
//   Command channel: a command (cmd) is transferred at a rising edge with start high and
//   busy low. Results come out on result, one per cycle, each marked by result_valid for
//   exactly one cycle; result.last flags the final result of a command. The receiver
//   cannot stall the block, so results are never held back.
//   Config port: wr_en/wr_index/wr_data write active_processes (index 0) or
//   active_resources (index 1); the user must write only while the block is idle,
//   the block itself does not enforce it. A request is checked against its need row,
//   then against available, then goes through the safety scan; a safety check runs
//   the scan, then emits the sequence. The scan walks one process row per cycle
//   through the row memory read port and the shared lane unit, pass after pass.
//   busy is high from the transfer until the cycle that carries the last result;
//   commands answered from idle (set available, invalid load or request) leave it low.
//   Reset: tables and the available vector read as zero, active_processes = 5,
//   active_resources = 3; row valid bits clear at once, so no clearing pass is needed.
module bankers_safety_and_request_check_top #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bsc_pkg::cmd_t                 cmd,
    output logic                          result_valid,
    output bsc_pkg::result_t              result,
    input  logic                          wr_en,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] wr_data
);
    import bsc_pkg::*;

    localparam int PW   = $clog2(MAX_PROCESSES);
    localparam int NP_W = $clog2(MAX_PROCESSES + 1);
    localparam int NR_W = $clog2(MAX_RESOURCES + 1);

    typedef logic [MAX_RESOURCES-1:0][AMT_W-1:0]  lane8_t;
    typedef logic [MAX_RESOURCES-1:0][WORK_W-1:0] lane12_t;

    // ---------------- configuration ----------------
    logic [4:0] act_proc_reg;
    logic [2:0] act_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_proc_reg <= ACTIVE_PROC_RST;
            act_res_reg  <= ACTIVE_RES_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_ACTIVE_PROC: act_proc_reg <= wr_data;
                CFG_ACTIVE_RES:  act_res_reg  <= wr_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped counts: out-of-range settings act as the nearest legal value
    logic [NP_W-1:0]          np;
    logic [NR_W-1:0]          nr;
    logic [MAX_RESOURCES-1:0] lane_act;

    always_comb
    begin
        if (act_proc_reg == '0)
            np = NP_W'(1);
        else if (int'(act_proc_reg) > MAX_PROCESSES)
            np = NP_W'(MAX_PROCESSES);
        else
            np = NP_W'(act_proc_reg);

        if (act_res_reg == '0)
            nr = NR_W'(1);
        else if (int'(act_res_reg) > MAX_RESOURCES)
            nr = NR_W'(MAX_RESOURCES);
        else
            nr = NR_W'(act_res_reg);

        for (int r = 0; r < MAX_RESOURCES; r++)
        begin
            lane_act[r] = (r < int'(nr));
        end
    end

    // ---------------- state ----------------
    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    lane8_t                   avail_reg, avail_next;
    lane12_t                  work_reg, work_next;
    lane8_t                   saved_alloc_reg, saved_need_reg;
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic [PW-1:0]            seq_reg [MAX_PROCESSES];
    logic [NP_W-1:0]          count_reg, count_next;
    logic                     found_reg, found_next;
    logic [PW-1:0]            eval_idx_reg, eval_idx_next;
    logic [PW-1:0]            out_idx_reg, out_idx_next;
    result_t                  result_reg, result_next;
    logic                     result_valid_reg, result_valid_next;

    // control flags for array writes and row save
    logic scan_clear, scan_hit, save_rows;

    // field lanes of the live command and of the held command
    logic [FIELD_LANES-1:0][AMT_W-1:0] in_amt, in_lim, hold_amt, hold_lim;

    assign in_amt   = {cmd.amt_3, cmd.amt_2, cmd.amt_1, cmd.amt_0};
    assign in_lim   = {cmd.limit_3, cmd.limit_2, cmd.limit_1, cmd.limit_0};
    assign hold_amt = {cmd_reg.amt_3, cmd_reg.amt_2, cmd_reg.amt_1, cmd_reg.amt_0};
    assign hold_lim = {cmd_reg.limit_3, cmd_reg.limit_2, cmd_reg.limit_1, cmd_reg.limit_0};

    // ---------------- row memory ----------------
    logic          mem_rd_en, mem_wr_en;
    logic [PW-1:0] mem_rd_addr, mem_wr_addr;
    lane8_t        rd_alloc, rd_need, mem_wr_alloc, mem_wr_need;

    bsc_row_mem #(
        .DEPTH (MAX_PROCESSES),
        .LANES (MAX_RESOURCES)
    ) u_rows (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_alloc (rd_alloc),
        .rd_need  (rd_need),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_alloc (mem_wr_alloc),
        .wr_need  (mem_wr_need)
    );

    // ---------------- shared lane unit ----------------
    lane12_t lu_base, lu_sum;
    lane8_t  lu_cmp, lu_add;
    logic    lu_fits;

    always_comb
    begin
        lu_base = work_reg;
        lu_cmp  = rd_need;
        lu_add  = rd_alloc;
        for (int r = 0; r < MAX_RESOURCES; r++)
        begin
            if (state_reg == S_RQ_RD)
            begin
                // request against remaining need
                lu_base[r] = WORK_W'(rd_need[r]);
                lu_cmp[r]  = hold_amt[r];
            end
            else if (state_reg == S_RQ_AV)
            begin
                // request against available
                lu_base[r] = WORK_W'(avail_reg[r]);
                lu_cmp[r]  = hold_amt[r];
            end
        end
    end

    bsc_lane_unit #(
        .LANES (MAX_RESOURCES)
    ) u_lanes (
        .lane_act (lane_act),
        .base     (lu_base),
        .cmp      (lu_cmp),
        .add      (lu_add),
        .fits     (lu_fits),
        .sum      (lu_sum)
    );

    // ---------------- sequencer ----------------
    logic          in_proc_ok, in_over, hold_proc_ok;
    logic          fit_now, pass_end, all_done, stuck;
    logic [PW-1:0] next_idx;

    always_comb
    begin
        in_proc_ok   = (int'(cmd.process) < int'(np));
        hold_proc_ok = (int'(cmd_reg.process) < int'(np));
        in_over      = 1'b0;
        for (int r = 0; r < MAX_RESOURCES; r++)
        begin
            if (lane_act[r] && (in_amt[r] > in_lim[r]))
            begin
                in_over = 1'b1;
            end
        end

        fit_now  = !finished_reg[eval_idx_reg] && lu_fits;
        pass_end = (int'(eval_idx_reg) + 1 == int'(np));
        all_done = fit_now && (int'(count_reg) + 1 == int'(np));
        stuck    = pass_end && !(found_reg || fit_now);
        next_idx = pass_end ? '0 : eval_idx_reg + PW'(1);
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        avail_next        = avail_reg;
        work_next         = work_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        eval_idx_next     = eval_idx_reg;
        out_idx_next      = out_idx_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        scan_clear        = 1'b0;
        scan_hit          = 1'b0;
        save_rows         = 1'b0;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = cmd.process[PW-1:0];
        mem_wr_en         = 1'b0;
        mem_wr_addr       = cmd_reg.process[PW-1:0];
        mem_wr_alloc      = saved_alloc_reg;
        mem_wr_need       = saved_need_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            if (!in_proc_ok || in_over)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{status: ST_INVALID, seq_process: '0, last: 1'b1};
                            end
                            else
                            begin
                                // read the row so inactive lanes keep their values
                                mem_rd_en  = 1'b1;
                                state_next = S_LD_RD;
                            end
                        end
                        OP_AVAIL:
                        begin
                            for (int r = 0; r < MAX_RESOURCES; r++)
                            begin
                                if (lane_act[r])
                                    avail_next[r] = in_amt[r];
                            end
                            result_valid_next = 1'b1;
                            result_next = '{status: ST_LOADED, seq_process: '0, last: 1'b1};
                        end
                        OP_REQ:
                        begin
                            if (!in_proc_ok)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{status: ST_INVALID, seq_process: '0, last: 1'b1};
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_RQ_RD;
                            end
                        end
                        OP_CHECK:
                        begin
                            state_next = S_SCAN_INIT;
                        end
                        default: ;
                    endcase
                end
            end

            S_LD_RD:
            begin
                mem_wr_en = hold_proc_ok;
                for (int r = 0; r < MAX_RESOURCES; r++)
                begin
                    mem_wr_alloc[r] = lane_act[r] ? hold_amt[r] : rd_alloc[r];
                    mem_wr_need[r]  = lane_act[r] ? hold_lim[r] - hold_amt[r] : rd_need[r];
                end
                result_valid_next = 1'b1;
                result_next = '{status: ST_LOADED, seq_process: '0, last: 1'b1};
                state_next  = S_IDLE;
            end

            S_RQ_RD:
            begin
                save_rows = 1'b1;
                if (!lu_fits)
                begin
                    result_valid_next = 1'b1;
                    result_next = '{status: ST_EXCEEDS, seq_process: '0, last: 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_RQ_AV;
                end
            end

            S_RQ_AV:
            begin
                if (!lu_fits)
                begin
                    result_valid_next = 1'b1;
                    result_next = '{status: ST_UNAVAIL, seq_process: '0, last: 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // apply tentatively, the scan decides whether it stays
                    mem_wr_en = 1'b1;
                    for (int r = 0; r < MAX_RESOURCES; r++)
                    begin
                        if (lane_act[r])
                        begin
                            mem_wr_alloc[r] = saved_alloc_reg[r] + hold_amt[r];
                            mem_wr_need[r]  = saved_need_reg[r] - hold_amt[r];
                            avail_next[r]   = avail_reg[r] - hold_amt[r];
                        end
                    end
                    state_next = S_SCAN_INIT;
                end
            end

            S_SCAN_INIT:
            begin
                for (int r = 0; r < MAX_RESOURCES; r++)
                begin
                    work_next[r] = lane_act[r] ? WORK_W'(avail_reg[r]) : '0;
                end
                scan_clear    = 1'b1;
                count_next    = '0;
                found_next    = 1'b0;
                eval_idx_next = '0;
                mem_rd_en     = 1'b1;
                mem_rd_addr   = '0;
                state_next    = S_SCAN;
            end

            S_SCAN:
            begin
                // evaluate the row read last cycle, fetch the next one
                mem_rd_en     = 1'b1;
                mem_rd_addr   = next_idx;
                eval_idx_next = next_idx;
                found_next    = pass_end ? 1'b0 : (found_reg || fit_now);
                if (fit_now)
                begin
                    scan_hit   = 1'b1;
                    work_next  = lu_sum;
                    count_next = count_reg + NP_W'(1);
                end
                if (all_done)
                begin
                    if (cmd_reg.op == OP_REQ)
                    begin
                        result_valid_next = 1'b1;
                        result_next = '{status: ST_GRANTED, seq_process: '0, last: 1'b1};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = '0;
                        state_next   = S_EMIT;
                    end
                end
                else if (stuck)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                    if (cmd_reg.op == OP_REQ)
                    begin
                        // roll the request back
                        mem_wr_en = 1'b1;
                        for (int r = 0; r < MAX_RESOURCES; r++)
                        begin
                            if (lane_act[r])
                                avail_next[r] = avail_reg[r] + hold_amt[r];
                        end
                        result_next = '{status: ST_DENIED, seq_process: '0, last: 1'b1};
                    end
                    else
                    begin
                        result_next = '{status: ST_UNSAFE, seq_process: '0, last: 1'b1};
                    end
                end
            end

            S_EMIT:
            begin
                result_valid_next = 1'b1;
                result_next.status      = ST_SEQ;
                result_next.seq_process = 4'(seq_reg[out_idx_reg]);
                result_next.last        = (int'(out_idx_reg) + 1 == int'(np));
                out_idx_next            = out_idx_reg + PW'(1);
                if (int'(out_idx_reg) + 1 == int'(np))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            avail_reg        <= '0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            found_reg        <= 1'b0;
            eval_idx_reg     <= '0;
            out_idx_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            avail_reg        <= avail_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
            found_reg        <= found_next;
            eval_idx_reg     <= eval_idx_next;
            out_idx_reg      <= out_idx_next;
        end
    end

    // payload and scratch, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        work_reg   <= work_next;
        result_reg <= result_next;
        if (save_rows)
        begin
            saved_alloc_reg <= rd_alloc;
            saved_need_reg  <= rd_need;
        end
        if (scan_clear)
        begin
            finished_reg <= '0;
        end
        else if (scan_hit)
        begin
            finished_reg[eval_idx_reg] <= 1'b1;
        end
        if (scan_hit)
        begin
            seq_reg[count_reg[PW-1:0]] <= eval_idx_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("block still busy after last result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("sequence cut short");

    a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_SEQ) |-> (result.seq_process == '0))
        else $error("seq_process set on non-sequence result");

    a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($countones(finished_reg) == int'(count_reg)))
        else $error("finished flags disagree with finish count");

endmodule

// File: sim/bankers_safety_and_request_check_top_tb.sv
`timescale 1ns / 1ps
// Testbench of the banker's checker: a directed command table, then random phases, all scored.

module bankers_safety_and_request_check_top_tb;
    import bsc_pkg::*;

    localparam int NPROC         = MAX_PROCESSES_DEF;
    localparam int NRES          = MAX_RESOURCES_DEF;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 56;
    localparam int SHOW_LIMIT    = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_t                  cmd;
    logic                  result_valid;
    result_t               result;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    bankers_safety_and_request_check_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow copy of the tables, the available vector and the registers
    logic [7:0] alloc_tab [NPROC][NRES];
    logic [7:0] need_tab  [NPROC][NRES];
    logic [7:0] avail_vec [NRES];
    logic [4:0] cfg_procs;
    logic [2:0] cfg_res;
    logic [3:0] finish_order [NPROC];

    result_t step_results [$];   // results of the command just predicted
    result_t outcome_q [$];      // results still owed by the block, oldest first

    int err_count;
    int cycle_count = 0;
    bit idle_ok;

    // one row of the directed table: a register write or a command
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        cmd_t                  c;
        bit                    typed;
        logic [2:0]            want_st;
    } dir_row_t;

    dir_row_t dir_tab [$];

    logic [4:0] phase_procs [PHASE_COUNT] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd2, 5'd0, 5'd9, 5'd16};
    logic [4:0] phase_res   [PHASE_COUNT] = '{5'd4, 5'd1, 5'd2, 5'd7, 5'd4, 5'd3, 5'd0, 5'd5};

    function automatic int procs_in_use();
        int n;
        n = int'(cfg_procs);
        if (n < 1) n = 1;
        if (n > NPROC) n = NPROC;
        return n;
    endfunction

    function automatic int res_in_use();
        int n;
        n = int'(cfg_res);
        if (n < 1) n = 1;
        if (n > NRES) n = NRES;
        return n;
    endfunction

    function automatic logic [7:0] lane_amt(cmd_t c, int r);
        case (r)
            0:       return c.amt_0;
            1:       return c.amt_1;
            2:       return c.amt_2;
            default: return c.amt_3;
        endcase
    endfunction

    function automatic logic [7:0] lane_lim(cmd_t c, int r);
        case (r)
            0:       return c.limit_0;
            1:       return c.limit_1;
            2:       return c.limit_2;
            default: return c.limit_3;
        endcase
    endfunction

    function automatic result_t res_of(logic [2:0] st, logic [3:0] sq, logic lst);
        result_t x;
        x.status      = st;
        x.seq_process = sq;
        x.last        = lst;
        return x;
    endfunction

    // Safety scan: passes in index order, a process may finish mid-pass.
    // Fills finish_order and returns 1 when every active process finishes.
    function automatic bit scan_safe();
        int np;
        int nr;
        int done_cnt;
        int w;
        bit found;
        bit fits;
        int work [NRES];
        bit done [NPROC];
        np = procs_in_use();
        nr = res_in_use();
        done_cnt = 0;
        for (int r = 0; r < NRES; r++)
            work[r] = (r < nr) ? int'(avail_vec[r]) : 0;
        for (int p = 0; p < NPROC; p++)
            done[p] = 1'b0;
        while (done_cnt < np)
        begin
            found = 1'b0;
            for (int p = 0; p < np; p++)
            begin
                if (!done[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++)
                        if (int'(need_tab[p][r]) > work[r]) fits = 1'b0;
                    if (fits)
                    begin
                        // work saturates at the top of its 12 bits
                        for (int r = 0; r < nr; r++)
                        begin
                            w = work[r] + int'(alloc_tab[p][r]);
                            work[r] = (w > int'(WORK_MAX)) ? int'(WORK_MAX) : w;
                        end
                        finish_order[done_cnt] = 4'(p);
                        done_cnt++;
                        done[p] = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            if (!found) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one command to the shadow state and lists the results it owes.
    function automatic void predict_cmd(cmd_t c);
        int np;
        int nr;
        int p;
        bit bad;
        bit over_need;
        bit over_avail;
        logic [7:0] amt [NRES];
        logic [7:0] lim [NRES];
        np = procs_in_use();
        nr = res_in_use();
        p = int'(c.process);
        step_results.delete();
        for (int r = 0; r < NRES; r++)
        begin
            amt[r] = lane_amt(c, r);
            lim[r] = lane_lim(c, r);
        end
        case (c.op)
            OP_LOAD:
            begin
                bad = (p >= np);
                for (int r = 0; r < nr; r++)
                    if (amt[r] > lim[r]) bad = 1'b1;
                if (!bad)
                    for (int r = 0; r < nr; r++)
                    begin
                        alloc_tab[p][r] = amt[r];
                        need_tab[p][r]  = lim[r] - amt[r];
                    end
                step_results.push_back(res_of(bad ? ST_INVALID : ST_LOADED, 4'd0, 1'b1));
            end
            OP_AVAIL:
            begin
                for (int r = 0; r < nr; r++)
                    avail_vec[r] = amt[r];
                step_results.push_back(res_of(ST_LOADED, 4'd0, 1'b1));
            end
            OP_REQ:
            begin
                if (p >= np)
                    step_results.push_back(res_of(ST_INVALID, 4'd0, 1'b1));
                else
                begin
                    over_need  = 1'b0;
                    over_avail = 1'b0;
                    for (int r = 0; r < nr; r++)
                    begin
                        if (amt[r] > need_tab[p][r]) over_need = 1'b1;
                        if (amt[r] > avail_vec[r]) over_avail = 1'b1;
                    end
                    if (over_need)
                        step_results.push_back(res_of(ST_EXCEEDS, 4'd0, 1'b1));
                    else if (over_avail)
                        step_results.push_back(res_of(ST_UNAVAIL, 4'd0, 1'b1));
                    else
                    begin
                        // tentative grant, rolled back when the scan fails
                        for (int r = 0; r < nr; r++)
                        begin
                            avail_vec[r]    = avail_vec[r] - amt[r];
                            alloc_tab[p][r] = alloc_tab[p][r] + amt[r];
                            need_tab[p][r]  = need_tab[p][r] - amt[r];
                        end
                        if (scan_safe())
                            step_results.push_back(res_of(ST_GRANTED, 4'd0, 1'b1));
                        else
                        begin
                            for (int r = 0; r < nr; r++)
                            begin
                                avail_vec[r]    = avail_vec[r] + amt[r];
                                alloc_tab[p][r] = alloc_tab[p][r] - amt[r];
                                need_tab[p][r]  = need_tab[p][r] + amt[r];
                            end
                            step_results.push_back(res_of(ST_DENIED, 4'd0, 1'b1));
                        end
                    end
                end
            end
            default:
            begin
                if (!scan_safe())
                    step_results.push_back(res_of(ST_UNSAFE, 4'd0, 1'b1));
                else
                    for (int k = 0; k < np; k++)
                        step_results.push_back(res_of(ST_SEQ, finish_order[k], k == np - 1));
            end
        endcase
    endfunction

    // Random command. force_op 0 loads a valid row for force_p, 1 sets available,
    // otherwise a weighted mix; a few commands are pure noise on every field.
    function automatic cmd_t random_cmd(int force_op, int force_p);
        cmd_t c;
        logic [95:0] raw;
        logic [7:0] amt [NRES];
        logic [7:0] lim [NRES];
        int np;
        int nr;
        int pick;
        int scale;
        int p;
        int cap;
        int bump;
        raw = {$urandom(), $urandom(), $urandom()};
        c = raw[$bits(cmd_t)-1:0];
        np = procs_in_use();
        nr = res_in_use();
        if (force_op < 0)
            pick = $urandom_range(0, 99);
        else
            pick = (force_op == 0) ? 10 : 30;
        if (pick < 8) return c;
        case ($urandom_range(0, 3))
            0:       scale = 3;
            1:       scale = 12;
            2:       scale = 60;
            default: scale = 255;
        endcase
        for (int r = 0; r < NRES; r++)
        begin
            amt[r] = lane_amt(c, r);
            lim[r] = lane_lim(c, r);
        end
        p = (force_p >= 0) ? force_p : $urandom_range(0, np - 1);
        if (pick < 26)
        begin
            c.op = OP_LOAD;
            for (int r = 0; r < nr; r++)
            begin
                lim[r] = 8'($urandom_range(0, scale));
                amt[r] = 8'($urandom_range(0, int'(lim[r])));
            end
            // now and then an allocation just above its limit
            if (force_p < 0 && $urandom_range(0, 7) == 0)
            begin
                bump = $urandom_range(0, nr - 1);
                if (lim[bump] != 8'hFF) amt[bump] = lim[bump] + 8'd1;
            end
        end
        else if (pick < 36)
        begin
            c.op = OP_AVAIL;
            for (int r = 0; r < nr; r++)
                amt[r] = 8'($urandom_range(0, scale));
        end
        else if (pick < 82)
        begin
            c.op = OP_REQ;
            if ($urandom_range(0, 11) == 0) p = $urandom_range(0, NPROC - 1);
            // mostly within need, and mostly within what is available too
            for (int r = 0; r < nr; r++)
            begin
                cap = int'(need_tab[p][r]);
                if ($urandom_range(0, 9) < 7 && int'(avail_vec[r]) < cap)
                    cap = int'(avail_vec[r]);
                amt[r] = 8'($urandom_range(0, cap));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                bump = $urandom_range(0, nr - 1);
                if (need_tab[p][bump] != 8'hFF) amt[bump] = need_tab[p][bump] + 8'd1;
            end
        end
        else
            c.op = OP_CHECK;
        c.process = 4'(p);
        c.amt_0   = amt[0];
        c.amt_1   = amt[1];
        c.amt_2   = amt[2];
        c.amt_3   = amt[3];
        c.limit_0 = lim[0];
        c.limit_1 = lim[1];
        c.limit_2 = lim[2];
        c.limit_3 = lim[3];
        return c;
    endfunction

    function automatic void add_cmd(logic [1:0] op, logic [3:0] p, logic [31:0] amts,
                                    logic [31:0] lims, bit typed, logic [2:0] st);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.c       = {op, p, amts, lims};
        row.typed   = typed;
        row.want_st = st;
        dir_tab.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.c       = '0;
        row.typed   = 1'b0;
        row.want_st = ST_LOADED;
        dir_tab.push_back(row);
    endfunction

    function automatic void log_mismatch(string what, result_t want, result_t got);
        err_count++;
        if (err_count <= SHOW_LIMIT)
            $display("[%0t] %s: expected status=%0d seq=%0d last=%0d, got status=%0d seq=%0d last=%0d",
                     $time, what, want.status, want.seq_process, want.last,
                     got.status, got.seq_process, got.last);
    endfunction

    // Presents one command, holds it until the transfer, then books its results.
    // Entered and left at a falling edge.
    task automatic send_cmd(cmd_t c, bit typed, logic [2:0] want_st);
        if (idle_ok && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        predict_cmd(c);
        if (typed)
            outcome_q.push_back(res_of(want_st, 4'd0, 1'b1));
        else
            foreach (step_results[k]) outcome_q.push_back(step_results[k]);
        @(negedge clk);
    endtask

    // Sender holds off until the block owes nothing, then lets it settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_ACTIVE_PROC)
            cfg_procs = val;
        else if (idx == CFG_ACTIVE_RES)
            cfg_res = val[2:0];
        @(negedge clk);
    endtask

    // result scoreboard: every strobed result against the oldest one owed
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_valid !== 1'b0)
        begin
            if (result_valid !== 1'b1)
                log_mismatch("result_valid unknown", 'x, result);
            else if (outcome_q.size() == 0)
                log_mismatch("result with nothing owed", 'x, result);
            else
            begin
                want = outcome_q.pop_front();
                if (result.status !== want.status || result.seq_process !== want.seq_process
                    || result.last !== want.last)
                    log_mismatch("result mismatch", want, result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bankers_safety_and_request_check_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int np_phase;
        start     = 1'b0;
        cmd       = '0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;
        rst_n     = 1'b0;
        err_count = 0;
        idle_ok   = 1'b1;
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
            begin
                alloc_tab[p][r] = 8'd0;
                need_tab[p][r]  = 8'd0;
            end
        for (int r = 0; r < NRES; r++)
            avail_vec[r] = 8'd0;
        cfg_procs = ACTIVE_PROC_RST;
        cfg_res   = ACTIVE_RES_RST;

        // directed table, reset config: 5 processes, 3 resources
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_SEQ);
        add_cmd(OP_LOAD,  4'd15, 32'h0,        32'h0,        1'b1, ST_INVALID);
        // resource 3 is inactive: its allocation above limit does not count
        add_cmd(OP_LOAD,  4'd0,  32'hFFFFFFFF, 32'hFFFFFF00, 1'b1, ST_LOADED);
        add_cmd(OP_LOAD,  4'd1,  32'h01000000, 32'h00FFFFFF, 1'b1, ST_INVALID);
        add_cmd(OP_LOAD,  4'd1,  32'h00000000, 32'hFFFFFFFF, 1'b1, ST_LOADED);
        add_cmd(OP_LOAD,  4'd2,  32'h0A141E00, 32'h28323C00, 1'b1, ST_LOADED);
        add_cmd(OP_AVAIL, 4'd0,  32'h00000000, 32'h0,        1'b1, ST_LOADED);
        add_cmd(OP_REQ,   4'd15, 32'h00000000, 32'h0,        1'b1, ST_INVALID);
        add_cmd(OP_REQ,   4'd2,  32'h1F000000, 32'h0,        1'b1, ST_EXCEEDS);
        add_cmd(OP_REQ,   4'd2,  32'h01010100, 32'h0,        1'b1, ST_UNAVAIL);
        add_cmd(OP_AVAIL, 4'd0,  32'hFFFFFFFF, 32'h0,        1'b1, ST_LOADED);
        add_cmd(OP_REQ,   4'd1,  32'hFFFFFF00, 32'h0,        1'b0, ST_GRANTED);
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_SEQ);
        // widest setting: all 16 processes, all 4 resources
        add_cfg(CFG_ACTIVE_PROC, 5'd16);
        add_cfg(CFG_ACTIVE_RES,  5'd4);
        add_cmd(OP_LOAD,  4'd15, 32'h00000080, 32'h000000FF, 1'b1, ST_LOADED);
        add_cmd(OP_REQ,   4'd15, 32'h00000080, 32'h0,        1'b1, ST_EXCEEDS);
        add_cmd(OP_AVAIL, 4'd0,  32'h05050505, 32'h0,        1'b1, ST_LOADED);
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_SEQ);
        // large needs against a small pool: unsafe check and a denied request
        add_cmd(OP_LOAD,  4'd0,  32'h00000000, 32'hC8C8C8C8, 1'b1, ST_LOADED);
        add_cmd(OP_LOAD,  4'd1,  32'h00000000, 32'hC8C8C8C8, 1'b1, ST_LOADED);
        add_cmd(OP_LOAD,  4'd2,  32'h00000000, 32'hC8C8C8C8, 1'b1, ST_LOADED);
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_UNSAFE);
        add_cmd(OP_REQ,   4'd0,  32'h01010101, 32'h0,        1'b0, ST_DENIED);
        // zero in both registers reads as one process, one resource
        add_cfg(CFG_ACTIVE_PROC, 5'd0);
        add_cfg(CFG_ACTIVE_RES,  5'd0);
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_UNSAFE);
        add_cmd(OP_LOAD,  4'd1,  32'h00000000, 32'h0,        1'b1, ST_INVALID);
        add_cmd(OP_REQ,   4'd0,  32'h06FFFFFF, 32'h0,        1'b1, ST_UNAVAIL);
        // values above range clamp to 16 and 4
        add_cfg(CFG_ACTIVE_PROC, 5'd31);
        add_cfg(CFG_ACTIVE_RES,  5'd7);
        add_cmd(OP_CHECK, 4'd0,  32'h0,        32'h0,        1'b0, ST_SEQ);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_drained();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
                send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want_st);
        end

        // random phases: each starts by loading every active row and the pool,
        // then mixes loads, pool updates, requests and checks
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_drained();
            write_reg(CFG_ACTIVE_PROC, phase_procs[ph]);
            write_reg(CFG_ACTIVE_RES, phase_res[ph]);
            idle_ok = (ph != 0);
            np_phase = procs_in_use();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
                if (k < np_phase)
                    send_cmd(random_cmd(0, k), 1'b0, ST_LOADED);
                else if (k == np_phase)
                    send_cmd(random_cmd(1, -1), 1'b0, ST_LOADED);
                else
                    send_cmd(random_cmd(-1, -1), 1'b0, ST_LOADED);
            end
        end

        wait_drained();
        if (err_count == 0 && outcome_q.size() == 0)
            $display("bankers_safety_and_request_check_top verification clean");
        else
            $display("bankers_safety_and_request_check_top verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/bsc_pkg.sv
design/bsc_row_mem.sv
design/bsc_lane_unit.sv
design/bankers_safety_and_request_check_top.sv
sim/bankers_safety_and_request_check_top_tb.sv
